/* hdl/bae_pkg.sv */
// ----------------------------------------------------------------------------
// bae_pkg
// Shared types, constants and checksum helpers of the Bech32 address encoder.
// ----------------------------------------------------------------------------
package bae_pkg;

   // Widest prefix the encoder handles
   localparam logic [3:0] HRP_MAX_CHARS = 4'd8;

   // Register indexes of the configuration port
   localparam logic [0:0] CSR_IDX_HRP_CHARS = 1'b0;
   localparam logic [0:0] CSR_IDX_HRP_LEN   = 1'b1;

   // Register reset values
   localparam logic [63:0] HRP_CHARS_RESET = 64'h0000_0000_0062_6b63;
   localparam logic [3:0]  HRP_LEN_RESET   = 4'd3;

   // Checksum start value and separator character
   localparam logic [29:0] CHECK_INIT = 30'd1;
   localparam logic [6:0]  SEP_CHAR   = 7'h31;

   // BCH generator constants of the polymod checksum
   localparam logic [29:0] GEN_POLY [5] = '{
      30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
   };

   // Symbol alphabet, symbol 0 in the top byte
   localparam logic [255:0] CHARSET = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";

   // Input transaction payload
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } bae_req_type;

   // Result transaction payload
   typedef struct packed {
      logic [6:0] ch;
      logic       last_char;
   } bae_rsp_type;

   // Work queue entry between front and back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       first_byte;
   } bae_entry_type;

   // One polymod step: shift in a 5-bit symbol
   function automatic logic [29:0] bch_fold(input logic [29:0] chk, input logic [4:0] v);
      logic [29:0] r;
      r = {chk[24:0], 5'b00000} ^ {25'd0, v};
      for (int j = 0; j < 5; j++) begin
         if (chk[25 + j]) begin
            r = r ^ GEN_POLY[j];
         end
      end
      return r;
   endfunction

   // Symbol to ASCII character
   function automatic logic [6:0] sym_char(input logic [4:0] s);
      logic [7:0] c;
      c = CHARSET[{~s, 3'b000} +: 8];
      return c[6:0];
   endfunction

endpackage

/* hdl/bech32_address_encoder_unit.sv */
// ----------------------------------------------------------------------------
// bech32_address_encoder_unit
// Streaming Bech32 address encoder: payload bytes in, ASCII characters out.
// ----------------------------------------------------------------------------
// Push payload bytes in order, last_byte set on the final one; pop ASCII
// characters, last_char set on the final checksum character. Within an
// address each byte completes one or two 5-bit symbols, 1.6 on average,
// each folded by the single checksum fold unit in the back-end sequencer,
// which emits at most one character per cycle, waiting while the result
// queue is full. The first byte is taken from the byte queue, then come
// the prefix, separator and prefix expansion. The last byte is followed by
// the pad symbol (when one is needed), six zero folds and six checksum
// characters. A byte queue in front and a result queue at the output let
// both sides stall independently. Configuration writes are always ready
// and are meant for when no address is in progress.
module bech32_address_encoder_unit #(
   parameter int REQ_DEPTH = 4,
   parameter int RSP_DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  bae_pkg::bae_req_type req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output bae_pkg::bae_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [0:0]           csr_index,
   input  logic [63:0]          csr_wdata
);
   import bae_pkg::*;

   localparam int RSP_W = $bits(bae_rsp_type);

   logic [63:0]   hrp_chars_ff, hrp_chars_in;
   logic [3:0]    hrp_len_ff, hrp_len_in;
   logic          q_valid;
   bae_entry_type q_entry;
   logic          q_pop;
   logic          rsp_push;
   bae_rsp_type   rsp_in;
   logic          rsp_full;
   logic [RSP_W-1:0] rsp_bits;

   // configuration registers
   assign csr_ready = 1'b1;

   always_comb begin
      hrp_chars_in = hrp_chars_ff;
      hrp_len_in   = hrp_len_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IDX_HRP_CHARS: hrp_chars_in = csr_wdata;
            CSR_IDX_HRP_LEN:   hrp_len_in   = csr_wdata[3:0];
            default:           hrp_len_in   = hrp_len_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hrp_chars_ff <= HRP_CHARS_RESET;
         hrp_len_ff   <= HRP_LEN_RESET;
      end else begin
         hrp_chars_ff <= hrp_chars_in;
         hrp_len_ff   <= hrp_len_in;
      end
   end

   // front end: accept and tag bytes
   bae_front #(
      .DEPTH (REQ_DEPTH)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_valid  (q_valid),
      .q_entry  (q_entry),
      .q_pop    (q_pop)
   );

   // back end: character sequencer and checksum
   bae_back u_back (
      .clock     (clock),
      .reset     (reset),
      .hrp_chars (hrp_chars_ff),
      .hrp_len   (hrp_len_ff),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_pop     (q_pop),
      .out_valid (rsp_push),
      .out_data  (rsp_in),
      .out_ready (!rsp_full)
   );

   // result queue
   bae_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_in),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_bits),
      .empty   (rsp_empty)
   );

   assign rsp_data = bae_rsp_type'(rsp_bits);

`ifndef SYNTHESIS
   // result queue comes out of reset empty
   a_rsp_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // an accepted byte is visible to the back end next cycle
   a_req_reaches_queue: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> q_valid)
      else $error("accepted byte missing from work queue");

   // the back end never loses a character into a full result queue
   a_no_rsp_overflow: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_full) |-> !q_pop)
      else $error("byte consumed while result queue full");
`endif

endmodule

/* hdl/bae_fifo.sv */
// ----------------------------------------------------------------------------
// bae_fifo
// Small register-based queue with push/pop and full/empty flags.
// ----------------------------------------------------------------------------
module bae_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* hdl/bae_front.sv */
// ----------------------------------------------------------------------------
// bae_front
// Accepts payload byte transactions, tags the first byte of each address and
// queues them for the back end.
// ----------------------------------------------------------------------------
module bae_front #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  bae_pkg::bae_req_type  req_data,
   output logic                  q_valid,
   output bae_pkg::bae_entry_type q_entry,
   input  logic                  q_pop
);
   import bae_pkg::*;

   localparam int ENTRY_W = $bits(bae_entry_type);

   logic          at_start_ff, at_start_in;
   logic          accept;
   logic          q_empty;
   bae_entry_type wr_entry;
   logic [ENTRY_W-1:0] rd_bits;

   assign accept = req_push && !req_full;

   // classify: the byte after an address end opens a new address
   assign wr_entry.data_byte  = req_data.data_byte;
   assign wr_entry.last_byte  = req_data.last_byte;
   assign wr_entry.first_byte = at_start_ff;

   always_comb begin
      at_start_in = at_start_ff;
      if (accept) begin
         at_start_in = req_data.last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff <= 1'b1;
      end else begin
         at_start_ff <= at_start_in;
      end
   end

   // work queue toward the back end
   bae_fifo #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_work_q (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (wr_entry),
      .full    (req_full),
      .pop     (q_pop),
      .rd_data (rd_bits),
      .empty   (q_empty)
   );

   assign q_valid = !q_empty;
   assign q_entry = bae_entry_type'(rd_bits);

endmodule

/* hdl/bae_back.sv */
// ----------------------------------------------------------------------------
// bae_back
// Sequencer that emits prefix, data symbols and checksum characters while
// running the polymod checksum, at most one fold per cycle.
// ----------------------------------------------------------------------------
module bae_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [63:0]            hrp_chars,
   input  logic [3:0]             hrp_len,
   input  logic                   q_valid,
   input  bae_pkg::bae_entry_type q_entry,
   output logic                   q_pop,
   output logic                   out_valid,
   output bae_pkg::bae_rsp_type   out_data,
   input  logic                   out_ready
);
   import bae_pkg::*;

   localparam logic [3:0] SYM_BITS     = 4'd5;
   localparam logic [3:0] BYTE_BITS    = 4'd8;
   localparam logic [3:0] CHK_LAST_IDX = 4'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HRP,
      ST_SEP,
      ST_HRP_LO,
      ST_DATA,
      ST_ZERO,
      ST_CHK
   } state_type;

   state_type   state_ff, state_in;
   logic [3:0]  idx_ff, idx_in;
   logic [29:0] check_ff, check_in;
   logic [11:0] acc_ff, acc_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic        last_ff, last_in;
   logic [3:0]  len_ff, len_in;

   logic [3:0]  sat_len;
   logic [7:0]  hrp_byte;
   logic        load;
   logic [11:0] eff_acc;
   logic [3:0]  eff_cnt;
   logic [3:0]  sym_shift;
   logic [11:0] sym_bits;
   logic [4:0]  sym;
   logic [8:0]  pad_bits;
   logic [4:0]  pad_sym;
   logic        sym_ready;
   logic [4:0]  fold_v;
   logic [29:0] check_fold;
   logic [3:0]  idx_next;

   assign sat_len  = (hrp_len > HRP_MAX_CHARS) ? HRP_MAX_CHARS : hrp_len;
   assign hrp_byte = hrp_chars[{idx_ff[2:0], 3'b000} +: 8];
   assign idx_next = idx_ff + 1'b1;

   // data path: merge the next byte once fewer than five bits are left
   assign load      = (state_ff == ST_DATA) && (cnt_ff < SYM_BITS) && !last_ff && q_valid;
   assign eff_acc   = load ? {acc_ff[3:0], q_entry.data_byte} : acc_ff;
   assign eff_cnt   = load ? cnt_ff + BYTE_BITS : cnt_ff;
   assign sym_ready = (eff_cnt >= SYM_BITS);
   assign sym_shift = eff_cnt - SYM_BITS;
   assign sym_bits  = eff_acc >> sym_shift[2:0];
   assign sym       = sym_bits[4:0];
   assign pad_bits  = {acc_ff[3:0], 5'b00000} >> cnt_ff;
   assign pad_sym   = pad_bits[4:0];

   // operand of the shared fold unit
   always_comb begin
      case (state_ff)
         ST_HRP:    fold_v = {2'b00, hrp_byte[7:5]};
         ST_HRP_LO: fold_v = hrp_byte[4:0];
         ST_DATA:   fold_v = sym_ready ? sym : pad_sym;
         default:   fold_v = 5'd0;
      endcase
   end

   assign check_fold = bch_fold(check_ff, fold_v);

   // sequencer next state
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      check_in  = check_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      last_in   = last_ff;
      len_in    = len_ff;
      q_pop     = 1'b0;
      out_valid = 1'b0;
      out_data  = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               acc_in  = {4'd0, q_entry.data_byte};
               cnt_in  = BYTE_BITS;
               last_in = q_entry.last_byte;
               idx_in  = '0;
               if (q_entry.first_byte) begin
                  check_in = CHECK_INIT;
                  len_in   = sat_len;
                  state_in = (sat_len == '0) ? ST_SEP : ST_HRP;
               end else begin
                  state_in = ST_DATA;
               end
            end
         end
         // prefix characters, folding their high bits
         ST_HRP: begin
            out_valid   = 1'b1;
            out_data.ch = hrp_byte[6:0];
            if (out_ready) begin
               check_in = check_fold;
               idx_in   = idx_next;
               if (idx_next == len_ff) begin
                  state_in = ST_SEP;
               end
            end
         end
         // separator, folding the zero between the halves
         ST_SEP: begin
            out_valid   = 1'b1;
            out_data.ch = SEP_CHAR;
            if (out_ready) begin
               check_in = check_fold;
               idx_in   = '0;
               state_in = (len_ff == '0) ? ST_DATA : ST_HRP_LO;
            end
         end
         // fold low bits of the prefix, no output
         ST_HRP_LO: begin
            check_in = check_fold;
            idx_in   = idx_next;
            if (idx_next == len_ff) begin
               state_in = ST_DATA;
            end
         end
         ST_DATA: begin
            if (sym_ready) begin
               out_valid   = 1'b1;
               out_data.ch = sym_char(sym);
               if (out_ready) begin
                  check_in = check_fold;
                  cnt_in   = sym_shift;
                  acc_in   = eff_acc;
                  if (load) begin
                     q_pop   = 1'b1;
                     last_in = q_entry.last_byte;
                  end
               end
            end else if (last_ff) begin
               if (cnt_ff != '0) begin
                  out_valid   = 1'b1;
                  out_data.ch = sym_char(pad_sym);
                  if (out_ready) begin
                     check_in = check_fold;
                     cnt_in   = '0;
                     idx_in   = '0;
                     state_in = ST_ZERO;
                  end
               end else begin
                  idx_in   = '0;
                  state_in = ST_ZERO;
               end
            end
         end
         // six zero folds, then the final xor
         ST_ZERO: begin
            idx_in = idx_next;
            if (idx_ff == CHK_LAST_IDX) begin
               check_in = check_fold ^ CHECK_INIT;
               idx_in   = '0;
               state_in = ST_CHK;
            end else begin
               check_in = check_fold;
            end
         end
         // checksum characters, top symbol first
         ST_CHK: begin
            out_valid          = 1'b1;
            out_data.ch        = sym_char(check_ff[29:25]);
            out_data.last_char = (idx_ff == CHK_LAST_IDX);
            if (out_ready) begin
               check_in = {check_ff[24:0], 5'b00000};
               idx_in   = idx_next;
               if (idx_ff == CHK_LAST_IDX) begin
                  cnt_in   = '0;
                  last_in  = 1'b0;
                  idx_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         check_ff <= CHECK_INIT;
         acc_ff   <= '0;
         cnt_ff   <= '0;
         last_ff  <= 1'b0;
         len_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         check_ff <= check_in;
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         last_ff  <= last_in;
         len_ff   <= len_in;
      end
   end

endmodule

/* sim/bech32_address_encoder_checker.sv */
// ----------------------------------------------------------------------------
// bech32_address_encoder_checker
// Watches the byte, character and register channels of the encoder and checks
// every popped character against its own model of the Bech32 encoding.
// ----------------------------------------------------------------------------
// Each accepted byte transaction is expanded into the characters it must
// produce (prefix and separator on an address start, data symbols, pad symbol
// and six checksum characters on the last byte). Popped characters are
// compared in order against that list. Register writes seen on the register
// channel update the model's prefix settings.
module bech32_address_encoder_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic                 req_full,
   input  bae_pkg::bae_req_type req_data,
   input  logic                 rsp_empty,
   input  logic                 rsp_pop,
   input  bae_pkg::bae_rsp_type rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [0:0]           csr_index,
   input  logic [63:0]          csr_wdata,
   output int                   mismatch_count,
   output int                   chars_pending
);
   import bae_pkg::*;

   // BCH generator terms, one per bit shifted out of the top of the checksum
   localparam logic [29:0] BCH_GEN [5] = '{
      30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
   };
   // Symbol alphabet, symbol 0 is the leftmost character
   localparam logic [255:0] ALPHABET   = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
   localparam logic [6:0]   SEPARATOR  = 7'h31;
   localparam logic [63:0]  PREFIX_CHARS_INIT = 64'h0000_0000_0062_6b63;
   localparam logic [3:0]   PREFIX_LEN_INIT   = 4'd3;
   localparam int           PREFIX_MAX        = 8;

   // Model state
   logic [63:0] prefix_chars;
   logic [3:0]  prefix_len;
   logic [29:0] polymod;
   logic [11:0] bit_buf;
   int          bit_cnt;
   logic        new_address;
   bae_rsp_type char_queue [$];

   // One polymod step: shift in a 5-bit symbol, reduce by the generator
   function automatic logic [29:0] polymod_step(input logic [29:0] chk,
                                                input logic [4:0] sym);
      logic [29:0] nxt;
      nxt = {chk[24:0], 5'd0} ^ {25'd0, sym};
      for (int j = 0; j < 5; j++) begin
         if (chk[25 + j]) begin
            nxt = nxt ^ BCH_GEN[j];
         end
      end
      return nxt;
   endfunction

   function automatic logic [6:0] alphabet_char(input logic [4:0] sym);
      return ALPHABET[8 * (31 - sym) +: 7];
   endfunction

   task automatic push_char(input logic [6:0] c, input logic fin);
      char_queue.push_back('{ch: c, last_char: fin});
   endtask

   // Data and pad symbols both go into the checksum
   task automatic emit_symbol(input logic [4:0] sym);
      polymod = polymod_step(polymod, sym);
      push_char(alphabet_char(sym), 1'b0);
   endtask

   task automatic clear_address();
      polymod     = 30'd1;
      bit_buf     = '0;
      bit_cnt     = 0;
      new_address = 1'b1;
   endtask

   // Characters caused by one accepted byte
   task automatic predict_byte(input bae_req_type item);
      int          n;
      logic [29:0] chk;
      if (new_address) begin
         // oversized prefix lengths saturate; zero length gives only the separator
         n = (prefix_len > PREFIX_MAX) ? PREFIX_MAX : int'(prefix_len);
         clear_address();
         for (int i = 0; i < n; i++) begin
            push_char(prefix_chars[8 * i +: 7], 1'b0);
         end
         push_char(SEPARATOR, 1'b0);
         // prefix expansion uses the full byte, bit 7 included
         for (int i = 0; i < n; i++) begin
            polymod = polymod_step(polymod, {2'b00, prefix_chars[8 * i + 5 +: 3]});
         end
         polymod = polymod_step(polymod, 5'd0);
         for (int i = 0; i < n; i++) begin
            polymod = polymod_step(polymod, prefix_chars[8 * i +: 5]);
         end
         new_address = 1'b0;
      end

      // regroup MSB first into 5-bit symbols
      bit_buf = {bit_buf[3:0], item.data_byte};
      bit_cnt = bit_cnt + 8;
      while (bit_cnt >= 5) begin
         bit_cnt = bit_cnt - 5;
         emit_symbol(5'(bit_buf >> bit_cnt));
      end
      bit_buf = bit_buf & ((12'd1 << bit_cnt) - 12'd1);

      if (item.last_byte) begin
         if (bit_cnt > 0) begin
            emit_symbol(5'(bit_buf << (5 - bit_cnt)));
         end
         chk = polymod;
         repeat (6) chk = polymod_step(chk, 5'd0);
         chk = chk ^ 30'd1;
         for (int k = 0; k < 6; k++) begin
            push_char(alphabet_char(chk[5 * (5 - k) +: 5]), k == 5);
         end
         clear_address();
      end
   endtask

   task automatic check_char(input bae_rsp_type got);
      bae_rsp_type want;
      if (char_queue.size() == 0) begin
         $error("unexpected character transaction: ch=%02h last_char=%0b",
                got.ch, got.last_char);
         mismatch_count++;
      end else begin
         want = char_queue.pop_front();
         if (got.ch !== want.ch) begin
            $error("ch: expected %02h, actual %02h", want.ch, got.ch);
            mismatch_count++;
         end
         if (got.last_char !== want.last_char) begin
            $error("last_char: expected %0b, actual %0b", want.last_char, got.last_char);
            mismatch_count++;
         end
      end
   endtask

   // Sample all channels at the rising edge; compare before predicting so an
   // empty queue is never filled by the same edge's byte
   always @(posedge clock) begin
      if (reset) begin
         prefix_chars   = PREFIX_CHARS_INIT;
         prefix_len     = PREFIX_LEN_INIT;
         clear_address();
         char_queue.delete();
         mismatch_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_IDX_HRP_CHARS: prefix_chars = csr_wdata;
               CSR_IDX_HRP_LEN:   prefix_len   = csr_wdata[3:0];
               default: ;
            endcase
         end
         if (rsp_pop && !rsp_empty) begin
            check_char(rsp_data);
         end
         if (req_push && !req_full) begin
            predict_byte(req_data);
         end
      end
      chars_pending = char_queue.size();
   end

endmodule

/* sim/tb_bech32_address_encoder_unit.sv */
// ----------------------------------------------------------------------------
// tb_bech32_address_encoder_unit
// Stimulus and verdict for the streaming Bech32 address encoder.
// ----------------------------------------------------------------------------
// Directed addresses cover byte extremes, addresses with and without a pad
// symbol, prefixes with high-bit characters, zero and oversized prefix
// lengths, and a prefix change in the middle of an address. Random addresses
// with random prefixes follow, under three idling patterns on the byte and
// character sides. All checking is done by the checker instance.
module tb_bech32_address_encoder_unit;
   import bae_pkg::*;

   localparam int SETTLE_CYCLES = 40;         // longest burst of one byte, rounded up
   localparam int RUN_LIMIT     = 5_000_000;  // time units

   logic        clock;
   logic        reset;
   logic        req_push;
   logic        req_full;
   bae_req_type req_data;
   logic        rsp_empty;
   logic        rsp_pop;
   bae_rsp_type rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [0:0]  csr_index;
   logic [63:0] csr_wdata;

   int mismatch_count;
   int chars_pending;
   int push_gap_pct = 0;
   int pop_gap_pct  = 0;

   bech32_address_encoder_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   bech32_address_encoder_checker char_check (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data       (req_data),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_data       (rsp_data),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .chars_pending  (chars_pending)
   );

   // Clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Character side: random pop stalls
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         rsp_pop <= !reset && ($urandom_range(0, 99) >= pop_gap_pct);
      end
   end

   // Watchdog
   initial begin
      #(RUN_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // One byte transaction, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] b, input logic lb);
      @(negedge clock);
      while ($urandom_range(0, 99) < push_gap_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_data <= '{data_byte: b, last_byte: lb};
      do @(posedge clock); while (req_full);
   endtask

   // Stop pushing and let every predicted character drain
   task automatic settle();
      @(negedge clock);
      req_push <= 1'b0;
      while (chars_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [0:0] idx, input logic [63:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_prefix(input logic [63:0] chars, input logic [3:0] len);
      settle();
      write_reg(CSR_IDX_HRP_CHARS, chars);
      write_reg(CSR_IDX_HRP_LEN, {60'd0, len});
   endtask

   // Mostly legal lengths, sometimes zero or oversized
   task automatic random_prefix();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         set_prefix({$urandom, $urandom}, 4'd0);
      end else if (pick == 1) begin
         set_prefix({$urandom, $urandom}, 4'($urandom_range(9, 15)));
      end else begin
         set_prefix({$urandom, $urandom}, 4'($urandom_range(1, 8)));
      end
   endtask

   // Random addresses; now and then the prefix changes mid-address
   task automatic random_phase(input int n_items, input int send_pct, input int recv_pct);
      int sent;
      int len;
      int split_at;
      push_gap_pct = send_pct;
      pop_gap_pct  = recv_pct;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 2) == 0) begin
            random_prefix();
         end
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
         split_at = ($urandom_range(0, 7) == 0 && len > 1) ? $urandom_range(1, len - 1) : -1;
         for (int i = 0; i < len; i++) begin
            if (i == split_at) begin
               random_prefix();
            end
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
         end
         sent = sent + len;
      end
      settle();
   endtask

   // Main sequence
   initial begin
      reset     = 1'b1;
      req_push  = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_IDX_HRP_CHARS;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      push_gap_pct = 20;
      pop_gap_pct  = 83;

      // reset prefix; single-byte addresses at both byte extremes
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      // three bytes, pad symbol needed
      send_byte(8'ha5, 1'b0);
      send_byte(8'h5a, 1'b0);
      send_byte(8'h0f, 1'b1);
      // five bytes fill whole symbols, no pad
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b0);
      send_byte(8'hfe, 1'b0);
      send_byte(8'h7f, 1'b0);
      send_byte(8'h00, 1'b1);

      // full-length prefix with high-bit characters
      set_prefix(64'hff80_e1a3_7b6c_9d01, 4'd8);
      send_byte(8'h3c, 1'b0);
      send_byte(8'hc3, 1'b1);
      // zero prefix length: separator only
      set_prefix(64'h0000_0000_0000_0061, 4'd0);
      send_byte(8'h42, 1'b1);
      // length above the maximum saturates
      set_prefix(64'h6f6e_6d6c_6b6a_6968, 4'd15);
      send_byte(8'h99, 1'b1);

      // prefix change mid-address applies at the next address only
      set_prefix(64'h0000_0000_7473_6574, 4'd4);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      set_prefix(64'h0000_0000_007a_7978, 4'd3);
      send_byte(8'h56, 1'b0);
      send_byte(8'h78, 1'b1);
      send_byte(8'h9a, 1'b1);

      // all-zero and all-one prefix bytes
      set_prefix(64'h0, 4'd1);
      send_byte(8'h01, 1'b1);
      set_prefix('1, 4'd8);
      send_byte(8'hfe, 1'b1);

      random_phase(55, 20, 83);
      random_phase(55, 83, 20);
      random_phase(55, 0, 0);

      if (mismatch_count == 0 && chars_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* sim.f */
hdl/bae_pkg.sv
hdl/bae_fifo.sv
hdl/bae_front.sv
hdl/bae_back.sv
hdl/bech32_address_encoder_unit.sv
sim/bech32_address_encoder_checker.sv
sim/tb_bech32_address_encoder_unit.sv
